FILE: rtl/core/qalu_pkg.sv
package qalu_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_ROT = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } sat_t;

    // clamp a wide signed value to the 32-bit range, flag when clamped
    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t res;
        res.ovf = 1'b0;
        res.val = v[DATA_W-1:0];
        if (!((v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1))) begin
            res.ovf = 1'b1;
            res.val = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/quaternion_alu_rotate.sv
// Pipeline: a request accepted at a clock edge passes through nine register stages (input,
//   two multiply ranks, adder ranks, saturation ranks) before its result shows on m_valid.
// Throughput: one request per cycle; a stalled output parks one result in a skid register
//   and holds the pipeline until it is taken.
// Reset: synchronous, active low on aresetn; clears all stage valid bits and the skid slot.
module quaternion_alu_rotate
    import qalu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_req_type,
    input  logic signed [DATA_W-1:0] s_a_x,
    input  logic signed [DATA_W-1:0] s_a_y,
    input  logic signed [DATA_W-1:0] s_a_z,
    input  logic signed [DATA_W-1:0] s_a_w,
    input  logic signed [DATA_W-1:0] s_b_x,
    input  logic signed [DATA_W-1:0] s_b_y,
    input  logic signed [DATA_W-1:0] s_b_z,
    input  logic signed [DATA_W-1:0] s_b_w,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_r_x,
    output logic signed [DATA_W-1:0] m_r_y,
    output logic signed [DATA_W-1:0] m_r_z,
    output logic signed [DATA_W-1:0] m_r_w,
    output logic                     m_overflow
);

    // Component order everywhere: 0 = x, 1 = y, 2 = z, 3 = w.

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipe advances together unless the skid
    // slot is occupied; s_ready therefore comes straight from a register.
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = !skid_valid_reg;

    // Stage 1: captured request
    op_t                     op1_reg;
    logic signed [DATA_W-1:0] a1_reg [4];
    logic signed [DATA_W-1:0] b1_reg [4];
    logic signed [DATA_W-1:0] b_eff  [4];

    // Stage 2: first product rank (all 16 cross products of a and b),
    // plus the finished add/subtract result
    op_t                      op2_reg;
    logic signed [DATA_W-1:0] a2_reg  [4];
    logic signed [PROD_W-1:0] p2_reg  [4][4];
    logic signed [DATA_W-1:0] as2_reg [4];
    logic                     aso2_reg;
    logic signed [DATA_W:0]   as_sum  [4];
    sat_t                     as_sat  [4];

    // Stage 3: pair sums of the first product
    op_t                      op3_reg;
    logic signed [DATA_W-1:0] a3_reg  [4];
    logic signed [PAIR_W-1:0] h3_reg  [4][2];
    logic signed [DATA_W-1:0] as3_reg [4];
    logic                     aso3_reg;

    // Stage 4: full sums of the first product
    op_t                      op4_reg;
    logic signed [DATA_W-1:0] a4_reg  [4];
    logic signed [ACC_W-1:0]  t4_reg  [4];
    logic signed [DATA_W-1:0] as4_reg [4];
    logic                     aso4_reg;

    // Stage 5: floored, saturated first result (or add/sub result)
    op_t                      op5_reg;
    logic signed [DATA_W-1:0] a5_reg   [4];
    logic signed [DATA_W-1:0] res5_reg [4];
    logic                     ovf5_reg;
    sat_t                     sat5     [4];
    logic                     ovf5_next;

    // Stage 6: second product rank, res5 times conj(a) for the vector lanes
    op_t                      op6_reg;
    logic signed [PROD_W-1:0] q6_reg   [3][4];
    logic signed [DATA_W-1:0] res6_reg [4];
    logic                     ovf6_reg;

    // Stage 7: pair differences of the second product
    op_t                      op7_reg;
    logic signed [PAIR_W-1:0] g7_reg   [3][2];
    logic signed [DATA_W-1:0] res7_reg [4];
    logic                     ovf7_reg;

    // Stage 8: full sums of the second product
    op_t                      op8_reg;
    logic signed [ACC_W-1:0]  u8_reg   [3];
    logic signed [DATA_W-1:0] res8_reg [4];
    logic                     ovf8_reg;

    // Stage 9: final result
    op_t                      op9_reg;
    logic signed [DATA_W-1:0] r9_reg   [4];
    logic                     ovf9_reg;
    sat_t                     sat9     [3];
    logic                     rot_ovf;

    // Skid slot
    logic signed [DATA_W-1:0] skid_r_reg [4];
    logic                     skid_ovf_reg;

    // ------------------------------------------------------------------
    // Valid bits: advance with the pipe, clear on reset.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // Skid slot: fill when the last stage moves on while the consumer
    // stalls, drain when the consumer takes the parked result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (v9_reg && !m_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            skid_r_reg   <= r9_reg;
            skid_ovf_reg <= ovf9_reg;
        end
    end

    // ------------------------------------------------------------------
    // Combinational helpers between stages
    // ------------------------------------------------------------------
    // Rotation treats b as a pure vector: drop its scalar part.
    always_comb begin
        b_eff[0] = b1_reg[0];
        b_eff[1] = b1_reg[1];
        b_eff[2] = b1_reg[2];
        b_eff[3] = (op1_reg == OP_ROT) ? '0 : b1_reg[3];
    end

    // Add/subtract: exact 33-bit result, then clamp.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (op1_reg == OP_SUB) begin
                as_sum[k] = (DATA_W+1)'(a1_reg[k]) - (DATA_W+1)'(b1_reg[k]);
            end else begin
                as_sum[k] = (DATA_W+1)'(a1_reg[k]) + (DATA_W+1)'(b1_reg[k]);
            end
            as_sat[k] = sat32(ACC_W'(as_sum[k]));
        end
    end

    // Flooring the exact sum equals summing floored terms plus the carried
    // fraction, so one arithmetic shift of the full sum is enough.
    always_comb begin
        ovf5_next = 1'b0;
        for (int k = 0; k < 4; k++) begin
            sat5[k]   = sat32(t4_reg[k] >>> FRAC_BITS);
            ovf5_next = ovf5_next | sat5[k].ovf;
        end
    end

    always_comb begin
        rot_ovf = 1'b0;
        for (int k = 0; k < 3; k++) begin
            sat9[k] = sat32(u8_reg[k] >>> FRAC_BITS);
            rot_ovf = rot_ovf | sat9[k].ovf;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers: hold while stalled, no reset.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            op1_reg   <= op_t'(s_req_type);
            a1_reg[0] <= s_a_x;
            a1_reg[1] <= s_a_y;
            a1_reg[2] <= s_a_z;
            a1_reg[3] <= s_a_w;
            b1_reg[0] <= s_b_x;
            b1_reg[1] <= s_b_y;
            b1_reg[2] <= s_b_z;
            b1_reg[3] <= s_b_w;

            // stage 2: 16 parallel 32x32 multipliers
            op2_reg  <= op1_reg;
            a2_reg   <= a1_reg;
            aso2_reg <= as_sat[0].ovf | as_sat[1].ovf | as_sat[2].ovf | as_sat[3].ovf;
            for (int i = 0; i < 4; i++) begin
                as2_reg[i] <= as_sat[i].val;
                for (int j = 0; j < 4; j++) begin
                    p2_reg[i][j] <= a1_reg[i] * b_eff[j];
                end
            end

            // stage 3: Hamilton product, pairwise
            op3_reg  <= op2_reg;
            a3_reg   <= a2_reg;
            as3_reg  <= as2_reg;
            aso3_reg <= aso2_reg;
            h3_reg[0][0] <= PAIR_W'(p2_reg[3][0]) + PAIR_W'(p2_reg[0][3]);
            h3_reg[0][1] <= PAIR_W'(p2_reg[1][2]) - PAIR_W'(p2_reg[2][1]);
            h3_reg[1][0] <= PAIR_W'(p2_reg[3][1]) + PAIR_W'(p2_reg[1][3]);
            h3_reg[1][1] <= PAIR_W'(p2_reg[2][0]) - PAIR_W'(p2_reg[0][2]);
            h3_reg[2][0] <= PAIR_W'(p2_reg[3][2]) + PAIR_W'(p2_reg[2][3]);
            h3_reg[2][1] <= PAIR_W'(p2_reg[0][1]) - PAIR_W'(p2_reg[1][0]);
            h3_reg[3][0] <= PAIR_W'(p2_reg[3][3]) - PAIR_W'(p2_reg[0][0]);
            h3_reg[3][1] <= -(PAIR_W'(p2_reg[1][1]) + PAIR_W'(p2_reg[2][2]));

            // stage 4
            op4_reg  <= op3_reg;
            a4_reg   <= a3_reg;
            as4_reg  <= as3_reg;
            aso4_reg <= aso3_reg;
            for (int k = 0; k < 4; k++) begin
                t4_reg[k] <= ACC_W'(h3_reg[k][0]) + ACC_W'(h3_reg[k][1]);
            end

            // stage 5: pick add/sub or the floored product
            op5_reg <= op4_reg;
            a5_reg  <= a4_reg;
            case (op4_reg) inside
                OP_ADD, OP_SUB: begin
                    res5_reg <= as4_reg;
                    ovf5_reg <= aso4_reg;
                end
                default: begin
                    for (int k = 0; k < 4; k++) begin
                        res5_reg[k] <= sat5[k].val;
                    end
                    ovf5_reg <= ovf5_next;
                end
            endcase

            // stage 6: m * conj(a); lane k keeps m_k*a_w, m_w*a_k and the
            // two cross terms, signs folded into the next adder rank
            op6_reg  <= op5_reg;
            res6_reg <= res5_reg;
            ovf6_reg <= ovf5_reg;
            for (int k = 0; k < 3; k++) begin
                q6_reg[k][0] <= res5_reg[k] * a5_reg[3];
                q6_reg[k][1] <= res5_reg[3] * a5_reg[k];
                q6_reg[k][2] <= res5_reg[(k + 2) % 3] * a5_reg[(k + 1) % 3];
                q6_reg[k][3] <= res5_reg[(k + 1) % 3] * a5_reg[(k + 2) % 3];
            end

            // stage 7
            op7_reg  <= op6_reg;
            res7_reg <= res6_reg;
            ovf7_reg <= ovf6_reg;
            for (int k = 0; k < 3; k++) begin
                g7_reg[k][0] <= PAIR_W'(q6_reg[k][0]) - PAIR_W'(q6_reg[k][1]);
                g7_reg[k][1] <= PAIR_W'(q6_reg[k][2]) - PAIR_W'(q6_reg[k][3]);
            end

            // stage 8
            op8_reg  <= op7_reg;
            res8_reg <= res7_reg;
            ovf8_reg <= ovf7_reg;
            for (int k = 0; k < 3; k++) begin
                u8_reg[k] <= ACC_W'(g7_reg[k][0]) + ACC_W'(g7_reg[k][1]);
            end

            // stage 9: rotation takes the second product, scalar forced to zero
            op9_reg <= op8_reg;
            if (op8_reg == OP_ROT) begin
                for (int k = 0; k < 3; k++) begin
                    r9_reg[k] <= sat9[k].val;
                end
                r9_reg[3] <= '0;
                ovf9_reg  <= ovf8_reg | rot_ovf;
            end else begin
                r9_reg   <= res8_reg;
                ovf9_reg <= ovf8_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: parked result first, else the last stage.
    // ------------------------------------------------------------------
    assign m_valid    = skid_valid_reg | v9_reg;
    assign m_r_x      = skid_valid_reg ? skid_r_reg[0] : r9_reg[0];
    assign m_r_y      = skid_valid_reg ? skid_r_reg[1] : r9_reg[1];
    assign m_r_z      = skid_valid_reg ? skid_r_reg[2] : r9_reg[2];
    assign m_r_w      = skid_valid_reg ? skid_r_reg[3] : r9_reg[3];
    assign m_overflow = skid_valid_reg ? skid_ovf_reg : ovf9_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> (v5_reg == $past(v4_reg)) && (v9_reg == $past(v8_reg)))
        else $error("stage valid lost or repeated on advance");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (v9_reg == $past(v9_reg)) && (v1_reg == $past(v1_reg)))
        else $error("pipeline moved while skid slot full");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(v9_reg) && !$past(m_ready))
        else $error("skid slot filled without a stalled result");

    a_rot_scalar: assert property (@(posedge aclk) disable iff (!aresetn)
        v9_reg && (op9_reg == OP_ROT) |-> (r9_reg[3] == '0))
        else $error("rotation result with nonzero scalar part");

endmodule

FILE: sim/tb_quaternion_alu_rotate.sv
`timescale 1ns / 100ps

module tb_quaternion_alu_rotate;
    import qalu_pkg::*;

    // Use the block's default fraction width; the predictor shares it.
    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int N_RANDOM     = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;   // more than the pipeline depth

    typedef logic signed [DATA_W-1:0] fix_t;    // one Q16.16 component
    typedef logic signed [DATA_W:0]   comp_t;   // room for a negated minimum
    typedef logic signed [PROD_W+3:0] wide_t;   // exact sum of four products

    localparam fix_t  MAXV    = 32'sh7FFF_FFFF;
    localparam fix_t  MINV    = 32'sh8000_0000;
    localparam fix_t  ONE     = 32'sh0001_0000;
    localparam fix_t  NEG_ONE = -32'sh0001_0000;
    localparam wide_t SAT_HI  = 68'sd2147483647;
    localparam wide_t SAT_LO  = -68'sd2147483648;

    typedef struct packed {
        op_t  op;
        fix_t ax, ay, az, aw;
        fix_t bx, by, bz, bw;
    } qreq_t;

    typedef struct packed {
        fix_t x, y, z, w;
        logic ovf;
    } qres_t;

    typedef struct packed {
        logic  known;   // expected result typed into the table
        qreq_t req;
        qres_t res;
    } dir_row_t;

    localparam qres_t NO_RES = '0;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  [1:0] s_req_type;
    fix_t  s_a_x, s_a_y, s_a_z, s_a_w;
    fix_t  s_b_x, s_b_y, s_b_z, s_b_w;
    logic  m_valid;
    logic  m_ready;
    fix_t  m_r_x, m_r_y, m_r_z, m_r_w;
    logic  m_overflow;

    qres_t    pending_results[$];   // results owed by the block, oldest first
    dir_row_t directed_rows[$];
    int       errors = 0;
    int       checked = 0;
    int       sat_count = 0;
    int       op_count[4] = '{0, 0, 0, 0};
    int       cycles = 0;
    int       rx_hold = 0;
    bit       tx_burst = 1'b0;
    bit       rx_burst = 1'b0;
    bit       sat_hit;              // saturation seen while predicting one request

    quaternion_alu_rotate #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_a_x      (s_a_x),
        .s_a_y      (s_a_y),
        .s_a_z      (s_a_z),
        .s_a_w      (s_a_w),
        .s_b_x      (s_b_x),
        .s_b_y      (s_b_y),
        .s_b_z      (s_b_z),
        .s_b_w      (s_b_w),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_r_x      (m_r_x),
        .m_r_y      (m_r_y),
        .m_r_z      (m_r_z),
        .m_r_w      (m_r_w),
        .m_overflow (m_overflow)
    );

    // 4 ns clock, low phase first.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp to 32 bits and remember that a clamp happened.
    function automatic fix_t clamp32(input wide_t v);
        if (v > SAT_HI) begin
            sat_hit = 1'b1;
            return MAXV;
        end
        if (v < SAT_LO) begin
            sat_hit = 1'b1;
            return MINV;
        end
        return v[DATA_W-1:0];
    endfunction

    // p0*q0 +/- p1*q1 +/- p2*q2 - p3*q3, formed exactly and floored by FRAC_BITS.
    // Flooring the exact sum equals summing floored terms plus the carried fractions.
    function automatic wide_t floored_sum(input comp_t p0, q0, p1, q1, p2, q2, p3, q3,
                                          input bit neg_mid);
        wide_t s;
        s = p0 * q0;
        if (neg_mid)
            s = s - p1 * q1 - p2 * q2;
        else
            s = s + p1 * q1 + p2 * q2;
        s = s - p3 * q3;
        return s >>> FRAC_BITS;
    endfunction

    // Hamilton product a*b; skip the scalar part when it is not wanted so that it
    // can never raise the saturation flag.
    function automatic void hamilton(input comp_t ax, ay, az, aw, bx, by, bz, bw,
                                     input bit want_w, output fix_t rx, ry, rz, rw);
        rx = clamp32(floored_sum(aw, bx, ax, bw, ay, bz, az, by, 1'b0));
        ry = clamp32(floored_sum(aw, by, ay, bw, az, bx, ax, bz, 1'b0));
        rz = clamp32(floored_sum(aw, bz, az, bw, ax, by, ay, bx, 1'b0));
        if (want_w)
            rw = clamp32(floored_sum(aw, bw, ax, bx, ay, by, az, bz, 1'b1));
        else
            rw = '0;
    endfunction

    function automatic qres_t compute_quat_result(input qreq_t rq);
        qres_t res;
        comp_t ax, ay, az, aw, bx, by, bz, bw;
        fix_t  mx, my, mz, mw;
        fix_t  rx, ry, rz, rw;
        ax = $signed(rq.ax);
        ay = $signed(rq.ay);
        az = $signed(rq.az);
        aw = $signed(rq.aw);
        bx = $signed(rq.bx);
        by = $signed(rq.by);
        bz = $signed(rq.bz);
        bw = $signed(rq.bw);
        sat_hit = 1'b0;
        rx = '0;
        ry = '0;
        rz = '0;
        rw = '0;
        case (rq.op)
            OP_ADD: begin
                rx = clamp32(ax + bx);
                ry = clamp32(ay + by);
                rz = clamp32(az + bz);
                rw = clamp32(aw + bw);
            end
            OP_SUB: begin
                rx = clamp32(ax - bx);
                ry = clamp32(ay - by);
                rz = clamp32(az - bz);
                rw = clamp32(aw - bw);
            end
            OP_MUL: begin
                hamilton(ax, ay, az, aw, bx, by, bz, bw, 1'b1, rx, ry, rz, rw);
            end
            OP_ROT: begin
                // a * (b vector, 0), clamped per component, then times conj(a)
                hamilton(ax, ay, az, aw, bx, by, bz, '0, 1'b1, mx, my, mz, mw);
                hamilton(mx, my, mz, mw, -ax, -ay, -az, aw, 1'b0, rx, ry, rz, rw);
            end
            default: ;
        endcase
        res.x   = rx;
        res.y   = ry;
        res.z   = rz;
        res.w   = rw;
        res.ovf = sat_hit;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic qreq_t mk_req(input op_t op, input fix_t ax, ay, az, aw,
                                     input fix_t bx, by, bz, bw);
        qreq_t rq;
        rq.op = op;
        rq.ax = ax;
        rq.ay = ay;
        rq.az = az;
        rq.aw = aw;
        rq.bx = bx;
        rq.by = by;
        rq.bz = bz;
        rq.bw = bw;
        return rq;
    endfunction

    function automatic qres_t mk_res(input fix_t x, y, z, w, input logic ovf);
        qres_t res;
        res.x   = x;
        res.y   = y;
        res.z   = z;
        res.w   = w;
        res.ovf = ovf;
        return res;
    endfunction

    task automatic row(input logic known, input qreq_t rq, input qres_t res);
        dir_row_t r;
        r.known = known;
        r.req   = rq;
        r.res   = res;
        directed_rows.push_back(r);
    endtask

    // Mix full-range words, scaled-down words, the corner values and small whole numbers.
    function automatic fix_t rand_field();
        fix_t v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: return v;
            3, 4:    return v >>> $urandom_range(1, 31);
            5: begin
                case ($urandom_range(0, 6))
                    0: return MAXV;
                    1: return MINV;
                    2: return '0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    5: return ONE;
                    default: return NEG_ONE;
                endcase
            end
            default: return ONE * ($urandom_range(0, 16) - 8);
        endcase
    endfunction

    // Near-unit quaternion: random direction, normalized in reals, then quantized.
    function automatic void unit_quat(output fix_t x, y, z, w);
        real cx, cy, cz, cw, n;
        int  k;
        k  = $urandom_range(0, 20000);
        cx = (k - 10000) / 10000.0;
        k  = $urandom_range(0, 20000);
        cy = (k - 10000) / 10000.0;
        k  = $urandom_range(0, 20000);
        cz = (k - 10000) / 10000.0;
        k  = $urandom_range(0, 20000);
        cw = (k - 10000) / 10000.0;
        n  = $sqrt(cx * cx + cy * cy + cz * cz + cw * cw);
        if (n < 0.01) begin
            x = '0;
            y = '0;
            z = '0;
            w = ONE;
        end else begin
            x = $rtoi(cx / n * 65536.0);
            y = $rtoi(cy / n * 65536.0);
            z = $rtoi(cz / n * 65536.0);
            w = $rtoi(cw / n * 65536.0);
        end
    endfunction

    function automatic qreq_t random_request();
        qreq_t rq;
        fix_t  v;
        rq.op = op_t'($urandom_range(0, 3));
        rq.ax = rand_field();
        rq.ay = rand_field();
        rq.az = rand_field();
        rq.aw = rand_field();
        rq.bx = rand_field();
        rq.by = rand_field();
        rq.bz = rand_field();
        rq.bw = rand_field();
        // Most products and rotations use a proper rotor and a moderate vector,
        // so the results land in range and exercise the rounding, not the clamp.
        if ((rq.op == OP_ROT || rq.op == OP_MUL) && $urandom_range(0, 9) < 7) begin
            unit_quat(rq.ax, rq.ay, rq.az, rq.aw);
            v = $urandom;
            rq.bx = v >>> $urandom_range(8, 31);
            v = $urandom;
            rq.by = v >>> $urandom_range(8, 31);
            v = $urandom;
            rq.bz = v >>> $urandom_range(8, 31);
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Request side: drive at the falling edge, hold until accepted
    // ------------------------------------------------------------------

    task automatic send_request(input qreq_t rq, input logic known, input qres_t typed_res);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        // Drop valid for the drawn gap; a zero gap keeps valid high back to back.
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type <= rq.op;
        s_a_x      <= rq.ax;
        s_a_y      <= rq.ay;
        s_a_z      <= rq.az;
        s_a_w      <= rq.aw;
        s_b_x      <= rq.bx;
        s_b_y      <= rq.by;
        s_b_z      <= rq.bz;
        s_b_w      <= rq.bw;
        s_valid    <= 1'b1;
        // Hold the request until the rising edge that takes it.
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(known ? typed_res : compute_quat_result(rq));
        op_count[int'(rq.op)]++;
        @(negedge aclk);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall at random, check at the rising edge
    // ------------------------------------------------------------------

    // Advance ready at the falling edge; hold it low for the drawn stall.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        qres_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: x=%h y=%h z=%h w=%h ovf=%b",
                       m_r_x, m_r_y, m_r_z, m_r_w, m_overflow);
                errors++;
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (m_r_x !== want.x) begin
                    $error("r_x: expected %h, got %h", want.x, m_r_x);
                    errors++;
                end
                if (m_r_y !== want.y) begin
                    $error("r_y: expected %h, got %h", want.y, m_r_y);
                    errors++;
                end
                if (m_r_z !== want.z) begin
                    $error("r_z: expected %h, got %h", want.z, m_r_z);
                    errors++;
                end
                if (m_r_w !== want.w) begin
                    $error("r_w: expected %h, got %h", want.w, m_r_w);
                    errors++;
                end
                if (m_overflow !== want.ovf) begin
                    $error("overflow: expected %b, got %b", want.ovf, m_overflow);
                    errors++;
                end
            end
            if (m_overflow === 1'b1)
                sat_count++;
            // Switch between stalling and a free-running sink now and then.
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            rx_hold = rx_burst ? 0 : $urandom_range(0, 5);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d results still owed",
                     cycles, pending_results.size());
            $display("tb_quaternion_alu_rotate NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        m_ready    = 1'b0;
        s_req_type = OP_ADD;
        s_a_x      = '0;
        s_a_y      = '0;
        s_a_z      = '0;
        s_a_w      = '0;
        s_b_x      = '0;
        s_b_y      = '0;
        s_b_z      = '0;
        s_b_w      = '0;

        // Directed table. Typed results are the ones obvious by hand; the
        // rest go through the predictor.
        // add: zero, one-sided overflow, both rails, max plus min
        row(1'b1, mk_req(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0), mk_res(0, 0, 0, 0, 1'b0));
        row(1'b1, mk_req(OP_ADD, MAXV, 0, 0, 0, 1, 0, 0, 0), mk_res(MAXV, 0, 0, 0, 1'b1));
        row(1'b1, mk_req(OP_ADD, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV),
            mk_res(MINV, MINV, MINV, MINV, 1'b1));
        row(1'b1, mk_req(OP_ADD, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV),
            mk_res(-1, -1, -1, -1, 1'b0));
        // subtract: negating the minimum, underflow, self difference
        row(1'b1, mk_req(OP_SUB, 0, 0, 0, 0, MINV, MINV, MINV, MINV),
            mk_res(MAXV, MAXV, MAXV, MAXV, 1'b1));
        row(1'b1, mk_req(OP_SUB, MINV, MINV, MINV, MINV, 1, 1, 1, 1),
            mk_res(MINV, MINV, MINV, MINV, 1'b1));
        row(1'b1, mk_req(OP_SUB, 32'sh1234_5678, -7, MAXV, MINV, 32'sh1234_5678, -7, MAXV, MINV),
            mk_res(0, 0, 0, 0, 1'b0));
        row(1'b0, mk_req(OP_SUB, 32'sh0003_8000, -5, 99, MAXV, NEG_ONE, 3, -99, -1), NO_RES);
        // product: identity, i*i, i*j, flooring of a tiny negative, extremes
        row(1'b1, mk_req(OP_MUL, 0, 0, 0, ONE, ONE, 2 * ONE, NEG_ONE, 32'sh8000),
            mk_res(ONE, 2 * ONE, NEG_ONE, 32'sh8000, 1'b0));
        row(1'b1, mk_req(OP_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0), mk_res(0, 0, 0, NEG_ONE, 1'b0));
        row(1'b1, mk_req(OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0), mk_res(0, 0, ONE, 0, 1'b0));
        row(1'b1, mk_req(OP_MUL, 0, 0, 0, 1, 0, 0, 0, -1), mk_res(0, 0, 0, -1, 1'b0));
        row(1'b1, mk_req(OP_MUL, 0, 0, 0, 1, 0, 0, 0, 1), mk_res(0, 0, 0, 0, 1'b0));
        row(1'b0, mk_req(OP_MUL, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV), NO_RES);
        row(1'b0, mk_req(OP_MUL, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), NO_RES);
        row(1'b0, mk_req(OP_MUL, MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV), NO_RES);
        row(1'b0, mk_req(OP_MUL, -3, 5, -7, 11, 13, -17, 19, -23), NO_RES);
        // rotate: identity ignores b_w, half turn about x, zero rotor,
        // non-unit rotor scales by its squared length, clamped intermediate
        row(1'b1, mk_req(OP_ROT, 0, 0, 0, ONE, ONE, 2 * ONE, -3 * ONE, MAXV),
            mk_res(ONE, 2 * ONE, -3 * ONE, 0, 1'b0));
        row(1'b1, mk_req(OP_ROT, ONE, 0, 0, 0, 0, ONE, 0, MINV), mk_res(0, NEG_ONE, 0, 0, 1'b0));
        row(1'b1, mk_req(OP_ROT, 0, 0, 0, 0, MAXV, MINV, MAXV, MINV), mk_res(0, 0, 0, 0, 1'b0));
        row(1'b1, mk_req(OP_ROT, 0, 0, 0, 2 * ONE, ONE, 0, 0, MAXV),
            mk_res(32'sh0004_0000, 0, 0, 0, 1'b0));
        row(1'b0, mk_req(OP_ROT, 0, 0, 46341, 46341, ONE, 0, 0, 0), NO_RES);
        row(1'b0, mk_req(OP_ROT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0), NO_RES);
        row(1'b0, mk_req(OP_ROT, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MAXV), NO_RES);
        row(1'b0, mk_req(OP_ROT, MINV, 0, 0, 1, 100 * ONE, -1, 1, 0), NO_RES);

        // Hold reset, then release it at a falling edge.
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res);

        // Let the pipeline empty completely before the random phase.
        drain_results();

        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 39) == 0)
                tx_burst = !tx_burst;
            // Midway, pause again until every owed result is back.
            if (n == N_RANDOM / 2)
                drain_results();
            send_request(random_request(), 1'b0, NO_RES);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("ran %0d requests: %0d add, %0d sub, %0d product, %0d rotate",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d results compared, %0d of them saturated, %0d mismatches",
                 checked, sat_count, errors);
        if (errors == 0)
            $display("tb_quaternion_alu_rotate OK");
        else
            $display("tb_quaternion_alu_rotate NOT OK");
        $finish;
    end

endmodule
